// ===== hdl/sbq_pkg.sv =====
package sbq_pkg;

   localparam int BANDS = 10;
   localparam int BAND_BITS = 4;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS = 32;
   localparam int COEF_FRAC_BITS = 29;
   localparam int STATE_BITS = 40;
   localparam int PROD_BITS = COEF_BITS + STATE_BITS;
   localparam int NCOEF = 5;
   localparam int CIDX_BITS = 6;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_PROCESS = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] SEL_B0 = 3'd0;
   localparam logic [2:0] SEL_B1 = 3'd1;
   localparam logic [2:0] SEL_B2 = 3'd2;
   localparam logic [2:0] SEL_A0 = 3'd3;
   localparam logic [2:0] SEL_A1 = 3'd4;
   localparam logic [2:0] SEL_A2 = 3'd5;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] band;
      logic [2:0] coef_select;
      logic signed [COEF_BITS-1:0] coef_value;
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   // control from sequencer to lanes
   typedef struct packed {
      logic load;
      logic clear;
      logic [2:0] step;
      logic [BAND_BITS-1:0] band;
      logic en;
   } lane_ctl_type;

   function automatic logic signed [STATE_BITS-1:0] rnd_shift(
      input logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS-1:0] t;
      begin
         t = p + (PROD_BITS'(1) <<< (COEF_FRAC_BITS - 1));
         rnd_shift = STATE_BITS'(t >>> COEF_FRAC_BITS);
      end
   endfunction

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [STATE_BITS+1:0] v);
      logic signed [STATE_BITS+1:0] hi;
      begin
         hi = (STATE_BITS+2)'((64'sd1 <<< (STATE_BITS - 1)) - 1);
         if (v > hi) sat_state = hi[STATE_BITS-1:0];
         else if (v < -hi - 1) sat_state = ~hi[STATE_BITS-1:0];
         else sat_state = v[STATE_BITS-1:0];
      end
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [STATE_BITS+1:0] v);
      logic signed [STATE_BITS+1:0] hi;
      begin
         hi = (STATE_BITS+2)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
         if (v > hi) sat_sample = hi[SAMPLE_BITS-1:0];
         else if (v < -hi - 1) sat_sample = ~hi[SAMPLE_BITS-1:0];
         else sat_sample = v[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

// ===== hdl/sbq_lane.sv =====
module sbq_lane
   import sbq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  lane_ctl_type ctl,
   input  logic signed [COEF_BITS-1:0] coef,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   // per-band delay states, one read slot each
   logic signed [STATE_BITS-1:0] s1_ff [BANDS];
   logic signed [STATE_BITS-1:0] s2_ff [BANDS];
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [STATE_BITS+1:0] acc_ff, acc_in;
   logic signed [STATE_BITS-1:0] bx2_ff, bx2_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [STATE_BITS-1:0] r;
   logic signed [SAMPLE_BITS-1:0] mop;

   // multiplier operand: x for b terms, y for a terms
   assign mop = (ctl.step == 3'd1 || ctl.step == 3'd2 || ctl.step == 3'd3) ? x_ff : y_ff;
   assign r = rnd_shift(prod_ff);

   // step sequence: 1 b0*x, 2 b1*x (y ready), 3 b2*x (s1 part), 4 a1*y, 5 a2*y
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      bx2_in = bx2_ff;
      if (ctl.load) x_in = sample_in;
      else if (ctl.en) begin
         case (ctl.step)
            3'd2: y_in = sat_sample((STATE_BITS+2)'(r) + (STATE_BITS+2)'(s1_ff[ctl.band]));
            3'd3: acc_in = (STATE_BITS+2)'(r) + (STATE_BITS+2)'(s2_ff[ctl.band]);
            3'd4: bx2_in = r;
            3'd6: x_in = y_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(coef) * PROD_BITS'(mop);
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      bx2_ff <= bx2_in;
   end

   // state updates: step 5 sees a1*y, step 6 sees a2*y
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < BANDS; i++) begin
            s1_ff[i] <= '0;
            s2_ff[i] <= '0;
         end
      end else if (ctl.en && ctl.step == 3'd5) begin
         s1_ff[ctl.band] <= sat_state(acc_ff - (STATE_BITS+2)'(r));
      end else if (ctl.en && ctl.step == 3'd6) begin
         s2_ff[ctl.band] <= sat_state((STATE_BITS+2)'(bx2_ff) - (STATE_BITS+2)'(r));
      end
   end

   assign sample_out = x_ff;

endmodule

// ===== hdl/stereo_biquad_cascade_eq.sv =====
// Stereo cascade of ten biquad bands (transposed direct form II), one
// coefficient set shared by a left and a right lane working side by side.
// A process transfer steps through every band in turn, one multiplier per
// lane forming the five products of each enabled band in turn; a bypassed
// band is still visited by the sequencer. Write and clear transfers take
// effect at the clock edge on which they are taken. The result sits in an
// output register, and the next request is taken once it has been delivered.
module stereo_biquad_cascade_eq
   import sbq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [BAND_BITS-1:0] band_ff, band_in;
   logic [2:0] step_ff, step_in;
   logic [BANDS-1:0] enable_ff;
   logic [COEF_BITS-1:0] coef_mem [BANDS*NCOEF];
   logic [COEF_BITS-1:0] coef_rd_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic req_xfer, rsp_xfer;
   lane_ctl_type ctl;
   logic signed [SAMPLE_BITS-1:0] left_y, right_y;
   logic [2:0] rd_sel;
   logic [2:0] wr_slot;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   // coefficient slot: b0 b1 b2 a1 a2
   assign wr_slot = (req_data.coef_select < SEL_A0) ? req_data.coef_select
                                                    : req_data.coef_select - 3'd1;
   // slot read for the product of the next step
   always_comb begin
      case (step_in)
         3'd1: rd_sel = 3'd0;
         3'd2: rd_sel = 3'd1;
         3'd3: rd_sel = 3'd2;
         3'd4: rd_sel = 3'd3;
         default: rd_sel = 3'd4;
      endcase
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (req_xfer && req_data.command == CMD_WRITE && req_data.band < BAND_BITS'(BANDS)
          && req_data.coef_select <= SEL_A2 && req_data.coef_select != SEL_A0)
         coef_mem[CIDX_BITS'(req_data.band) * CIDX_BITS'(NCOEF) + CIDX_BITS'(wr_slot)]
            <= req_data.coef_value;
      coef_rd_ff <= coef_mem[CIDX_BITS'(band_in) * CIDX_BITS'(NCOEF) + CIDX_BITS'(rd_sel)];
   end

   // band enables
   always_ff @(posedge clock) begin
      if (reset) enable_ff <= '0;
      else if (req_xfer && req_data.command == CMD_WRITE
               && req_data.band < BAND_BITS'(BANDS) && req_data.coef_select == SEL_A0)
         enable_ff[req_data.band] <= (req_data.coef_value != '0);
   end

   // sequencer over bands and steps
   always_comb begin
      state_in = state_ff;
      band_in = band_ff;
      step_in = step_ff;
      case (state_ff)
         ST_IDLE: begin
            band_in = '0;
            step_in = 3'd0;
            if (req_xfer && req_data.command == CMD_PROCESS) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (!enable_ff[band_ff] || step_ff == 3'd6) begin
               step_in = 3'd0;
               if (band_ff == BAND_BITS'(BANDS - 1)) state_in = ST_DONE;
               else band_in = band_ff + 1'b1;
            end else step_in = step_ff + 3'd1;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         band_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         band_ff <= band_in;
         step_ff <= step_in;
      end
   end

   assign ctl.load = req_xfer && req_data.command == CMD_PROCESS;
   assign ctl.clear = req_xfer && req_data.command == CMD_CLEAR;
   assign ctl.step = step_ff;
   assign ctl.band = band_ff;
   assign ctl.en = (state_ff == ST_RUN) && enable_ff[band_ff];

   sbq_lane u_left (
      .clock(clock), .reset(reset), .ctl(ctl), .coef(coef_rd_ff),
      .sample_in(req_data.left_in), .sample_out(left_y)
   );
   sbq_lane u_right (
      .clock(clock), .reset(reset), .ctl(ctl), .coef(coef_rd_ff),
      .sample_in(req_data.right_in), .sample_out(right_y)
   );

   // merge lanes into the result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
      else if (rsp_xfer) rsp_valid_ff <= 1'b0;
      if (state_ff == ST_DONE) begin
         rsp_ff.left_out <= left_y;
         rsp_ff.right_out <= right_y;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> !req_xfer) else $error("request taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid) else $error("result not raised");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'd6) else $error("step overflow");

endmodule
